// ----- hw/rtl/bmrfc_pkg.sv -----
package bmrfc_pkg;

  localparam int WORD_W  = 64;   // bits per stored word
  localparam int WORDS   = 64;   // words in the bitmap
  localparam int WADDR_W = 6;    // word address inside the store
  localparam int XADDR_W = 8;    // extended word address, values past the store read as zero
  localparam int BIT_W   = 13;   // bit position / bit count
  localparam int FUNC_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CUT   = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [WADDR_W-1:0] word_index;
    logic [WORD_W-1:0]  word_value;
    logic [BIT_W-1:0]   first_bit;
    logic [BIT_W-1:0]   cut_count;
    logic [BIT_W-1:0]   end_bit;
  } in_t;

  typedef struct packed {
    logic [BIT_W-1:0]  run_start;
    logic [BIT_W-1:0]  run_end;
    logic [WORD_W-1:0] read_value;
  } out_t;

  typedef struct packed {
    logic               en;
    logic [XADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
    logic [WORD_W-1:0]  data;
  } wr_req_t;

endpackage

// ----- hw/rtl/bmrfc_store.sv -----
module bmrfc_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bmrfc_pkg::rd_req_t         rd_a,
  input  bmrfc_pkg::rd_req_t         rd_b,
  input  bmrfc_pkg::wr_req_t         wr,
  output logic [bmrfc_pkg::WORD_W-1:0] qa,
  output logic [bmrfc_pkg::WORD_W-1:0] qb
);
  import bmrfc_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  valid_r;
  logic [WORD_W-1:0] qa_r;
  logic [WORD_W-1:0] qb_r;
  logic              hit_a_r;
  logic              hit_b_r;

  // valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_a.en) begin
      qa_r    <= mem[rd_a.addr[WADDR_W-1:0]];
      hit_a_r <= (rd_a.addr[XADDR_W-1:WADDR_W] == '0) && valid_r[rd_a.addr[WADDR_W-1:0]];
    end
    if (rd_b.en) begin
      qb_r    <= mem[rd_b.addr[WADDR_W-1:0]];
      hit_b_r <= (rd_b.addr[XADDR_W-1:WADDR_W] == '0) && valid_r[rd_b.addr[WADDR_W-1:0]];
    end
  end

  assign qa = hit_a_r ? qa_r : '0;
  assign qb = hit_b_r ? qb_r : '0;

endmodule

// ----- hw/rtl/bitmap_run_find_and_cut_unit.sv -----
// Bitmap of 64 words x 64 bits with word write/read, set-run search and in-place bit cut.
//
// Request channel (in_valid/in_ready/in_data): one request per handshake; func selects
// write word, read word, find set run, or cut bits. in_ready is high only while the
// unit is idle; requests are handled one at a time.
// Result channel (out_valid/out_ready/out_data): exactly one result per request, held in
// an output register. The next request is taken while a result still waits there.
//
// Steps per request, from accept to result in the output register:
//   write: dispatch, store write, push; read: dispatch, store read, capture, push,
//   find:  dispatch, a fetch and an evaluate step per word fetched, one more evaluate
//         step once a run start is found, a last fetch step when the walk stops there
//         (end bit reached or past the stored bits), then push,
//   cut:   dispatch, prime, load, then one word per cycle from the word of first_bit to
//         that of end_bit (at most 64 words) through the store's two read ports and one
//         write port, then push; a cut that changes nothing goes from dispatch to push.
// in_ready rises as the result is registered. A request whose result cannot enter the
// output register waits in its final state while out_ready is low; nothing is dropped.
// Reset (rst_n low, synchronous) clears the per-word valid bits, so the whole bitmap
// reads as zero right away: no clearing pass.
module bitmap_run_find_and_cut_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bmrfc_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bmrfc_pkg::out_t out_data
);
  import bmrfc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_WR     = 4'd2;
  localparam logic [3:0] S_RD     = 4'd3;
  localparam logic [3:0] S_RDW    = 4'd4;
  localparam logic [3:0] S_FFETCH = 4'd5;
  localparam logic [3:0] S_FEVAL  = 4'd6;
  localparam logic [3:0] S_CPRIME = 4'd7;
  localparam logic [3:0] S_CLOAD  = 4'd8;
  localparam logic [3:0] S_CRUN   = 4'd9;
  localparam logic [3:0] S_PUSH   = 4'd10;

  // mask of the bits of word w whose global position lies below t
  function automatic logic [WORD_W-1:0] below_mask(input logic [WADDR_W-1:0] w,
                                                   input logic [BIT_W-1:0] t);
    logic [BIT_W-WADDR_W-1:0] tw;
    logic [WORD_W-1:0]        m;
    tw = t[BIT_W-1:WADDR_W];
    if (tw > {1'b0, w}) begin
      m = '1;
    end else if (tw == {1'b0, w}) begin
      m = ~({WORD_W{1'b1}} << t[WADDR_W-1:0]);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  // index of the lowest set bit
  function automatic logic [WADDR_W-1:0] lsb_idx(input logic [WORD_W-1:0] v);
    logic [WADDR_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WADDR_W'(i);
      end
    end
    return idx;
  endfunction

  // ---------------- registers ----------------
  logic [3:0]          state_r, state_nxt;
  in_t                 req_r, req_nxt;
  out_t                res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;
  // find walk
  logic [BIT_W-1:0]    pos_r, pos_nxt;
  logic                phase_r, phase_nxt;     // 0: looking for a set bit, 1: for a clear bit
  // cut walk
  logic [WADDR_W-1:0]  w_r, w_nxt;             // destination word
  logic [WADDR_W-1:0]  wlast_r, wlast_nxt;
  logic [XADDR_W-1:0]  s_r, s_nxt;             // low source word for w_r
  logic [WORD_W-1:0]   win_r, win_nxt;         // low source word data

  // ---------------- store ----------------
  rd_req_t             rd_a, rd_b;
  wr_req_t             wr;
  logic [WORD_W-1:0]   qa, qb;

  bmrfc_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_a  (rd_a),
    .rd_b  (rd_b),
    .wr    (wr),
    .qa    (qa),
    .qb    (qb)
  );

  // ---------------- find datapath ----------------
  logic [WORD_W-1:0]   word_mask;
  logic [WORD_W-1:0]   find_hits;
  logic [WADDR_W-1:0]  hit_idx;
  logic [BIT_W-1:0]    hit_pos;
  logic [BIT_W-1:0]    next_word_pos;
  logic [BIT_W-1:0]    find_start;

  assign word_mask     = {WORD_W{1'b1}} << pos_r[WADDR_W-1:0];
  assign find_hits     = phase_r ? (~qa & word_mask) : (qa & word_mask);
  assign hit_idx       = lsb_idx(find_hits);
  assign hit_pos       = {pos_r[BIT_W-1:WADDR_W], hit_idx};
  assign next_word_pos = {pos_r[BIT_W-1:WADDR_W] + 7'd1, {WADDR_W{1'b0}}};
  assign find_start    = (req_r.first_bit < req_r.end_bit) ? req_r.first_bit : req_r.end_bit;

  // ---------------- cut datapath ----------------
  // destination bit g takes source bit g + cut_count when that lies below end_bit,
  // otherwise zero; bits outside [first_bit, end_bit) keep their value
  logic [2*WORD_W-1:0] pair_sh;
  logic [BIT_W-1:0]    src_lim;
  logic [WORD_W-1:0]   in_range;
  logic [WORD_W-1:0]   cut_word;
  logic                cut_skip;
  logic [BIT_W-1:0]    end_m1;
  logic [XADDR_W-1:0]  s_first;

  assign pair_sh  = {qb, win_r} >> req_r.cut_count[WADDR_W-1:0];
  assign src_lim  = (req_r.end_bit > req_r.cut_count) ? (req_r.end_bit - req_r.cut_count)
                                                       : '0;
  assign in_range = ~below_mask(w_r, req_r.first_bit) & below_mask(w_r, req_r.end_bit);
  assign cut_word = (qa & ~in_range)
                  | (pair_sh[WORD_W-1:0] & below_mask(w_r, src_lim) & in_range);
  assign cut_skip = (req_r.first_bit >= req_r.end_bit) || (req_r.cut_count == '0)
                  || req_r.first_bit[BIT_W-1];
  assign end_m1   = req_r.end_bit - 13'd1;
  assign s_first  = {2'b00, req_r.first_bit[11:6]} + {1'b0, req_r.cut_count[BIT_W-1:WADDR_W]};

  // ---------------- control ----------------
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    w_nxt         = w_r;
    wlast_nxt     = wlast_r;
    s_nxt         = s_r;
    win_nxt       = win_r;
    rd_a          = '0;
    rd_b          = '0;
    wr            = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_nxt = '0;
        unique case (req_r.func)
          FUNC_WRITE: state_nxt = S_WR;
          FUNC_READ:  state_nxt = S_RD;
          FUNC_FIND: begin
            pos_nxt   = find_start;
            phase_nxt = 1'b0;
            state_nxt = S_FFETCH;
          end
          FUNC_CUT: begin
            if (cut_skip) begin
              state_nxt = S_PUSH;
            end else begin
              w_nxt     = req_r.first_bit[11:6];
              s_nxt     = s_first;
              wlast_nxt = req_r.end_bit[BIT_W-1] ? 6'd63 : end_m1[11:6];
              state_nxt = S_CPRIME;
            end
          end
        endcase
      end
      S_WR: begin
        wr.en     = 1'b1;
        wr.addr   = req_r.word_index;
        wr.data   = req_r.word_value;
        state_nxt = S_PUSH;
      end
      S_RD: begin
        rd_a.en   = 1'b1;
        rd_a.addr = {2'b00, req_r.word_index};
        state_nxt = S_RDW;
      end
      S_RDW: begin
        res_nxt.read_value = qa;
        state_nxt          = S_PUSH;
      end
      S_FFETCH: begin
        if (pos_r >= req_r.end_bit) begin
          if (!phase_r) begin
            res_nxt.run_start = req_r.end_bit;
          end
          res_nxt.run_end = req_r.end_bit;
          state_nxt       = S_PUSH;
        end else if (pos_r[BIT_W-1]) begin
          // past the stored bits: all clear
          if (!phase_r) begin
            res_nxt.run_start = req_r.end_bit;
            res_nxt.run_end   = req_r.end_bit;
          end else begin
            res_nxt.run_end = pos_r;
          end
          state_nxt = S_PUSH;
        end else begin
          rd_a.en   = 1'b1;
          rd_a.addr = {1'b0, pos_r[BIT_W-1:WADDR_W]};
          state_nxt = S_FEVAL;
        end
      end
      S_FEVAL: begin
        if (find_hits == '0) begin
          pos_nxt   = next_word_pos;
          state_nxt = S_FFETCH;
        end else if (!phase_r) begin
          if (hit_pos >= req_r.end_bit) begin
            res_nxt.run_start = req_r.end_bit;
            res_nxt.run_end   = req_r.end_bit;
            state_nxt         = S_PUSH;
          end else begin
            // run starts here; look for its end in the same word next cycle
            res_nxt.run_start = hit_pos;
            pos_nxt           = hit_pos;
            phase_nxt         = 1'b1;
          end
        end else begin
          res_nxt.run_end = (hit_pos < req_r.end_bit) ? hit_pos : req_r.end_bit;
          state_nxt       = S_PUSH;
        end
      end
      S_CPRIME: begin
        rd_b.en   = 1'b1;
        rd_b.addr = s_r;
        state_nxt = S_CLOAD;
      end
      S_CLOAD: begin
        win_nxt   = qb;
        rd_a.en   = 1'b1;
        rd_a.addr = {2'b00, w_r};
        rd_b.en   = 1'b1;
        rd_b.addr = s_r + 8'd1;
        state_nxt = S_CRUN;
      end
      S_CRUN: begin
        // sources sit at or above the destination, so reads never see a cut word
        wr.en   = 1'b1;
        wr.addr = w_r;
        wr.data = cut_word;
        win_nxt = qb;
        if (w_r == wlast_r) begin
          state_nxt = S_PUSH;
        end else begin
          w_nxt     = w_r + 6'd1;
          s_nxt     = s_r + 8'd1;
          rd_a.en   = 1'b1;
          rd_a.addr = {2'b00, 6'(w_r + 6'd1)};
          rd_b.en   = 1'b1;
          rd_b.addr = s_r + 8'd2;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    pos_r      <= pos_nxt;
    phase_r    <= phase_nxt;
    w_r        <= w_nxt;
    wlast_r    <= wlast_nxt;
    s_r        <= s_nxt;
    win_r      <= win_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_no_rw_same_a: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && rd_a.en) |-> ({2'b00, wr.addr} != rd_a.addr))
    else $error("store read port A hits the word being written");

  a_src_above_dst: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && rd_b.en) |-> ({2'b00, wr.addr} < rd_b.addr))
    else $error("cut source read not above the destination word");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISP))
    else $error("accepted request not dispatched");

  a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && out_valid_r && !out_ready) |=> (state_r == S_PUSH && out_valid_r))
    else $error("result pushed over a waiting result");

endmodule

// ----- tb/tb_bitmap_run_find_and_cut_unit.sv -----
module tb_bitmap_run_find_and_cut_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bmrfc_pkg::*;

  // total bits held by the store; positions at or past this read as zero
  localparam int STORE_BITS = WORDS * WORD_W;
  localparam int BIT_MAX    = (1 << BIT_W) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // idle / stall odds out of 100, changed per traffic phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // shadow copy of the bitmap, updated in acceptance order; all zero like the store
  logic [WORD_W-1:0] shadow_bitmap [WORDS] = '{default: '0};
  out_t expected_results [$];
  int error_count = 0;
  int unsigned op_count [4];
  int unsigned results_checked = 0;

  bitmap_run_find_and_cut_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bit lookup with the store edge: anything past the last word is zero.
  function automatic bit shadow_bit(int pos);
    if (pos >= STORE_BITS) return 1'b0;
    return shadow_bitmap[pos / WORD_W][pos % WORD_W];
  endfunction

  // Apply one request to the shadow bitmap and return the result it should produce.
  function automatic out_t predict_result(in_t req);
    out_t res;
    int first;
    int last;
    int cnt;
    int pos;
    int src;
    bit v;
    res = '0;
    first = req.first_bit;
    last = req.end_bit;
    cnt = req.cut_count;
    case (req.func)
      FUNC_WRITE: shadow_bitmap[req.word_index] = req.word_value;
      FUNC_READ: res.read_value = shadow_bitmap[req.word_index];
      FUNC_FIND: begin
        // start clipped to the end, then skip clear bits, then walk the set run
        pos = (first < last) ? first : last;
        while (pos < last && !shadow_bit(pos)) pos++;
        res.run_start = pos[BIT_W-1:0];
        while (pos < last && shadow_bit(pos)) pos++;
        res.run_end = pos[BIT_W-1:0];
      end
      default: begin
        // in-place cut, low to high: the source is never below the destination
        for (pos = first; pos < last; pos++) begin
          src = pos + cnt;
          v = (src < last) ? shadow_bit(src) : 1'b0;
          if (pos < STORE_BITS) shadow_bitmap[pos / WORD_W][pos % WORD_W] = v;
        end
      end
    endcase
    return res;
  endfunction

  // Bit position: mostly inside the store, sometimes past it up to the field's top.
  function automatic logic [BIT_W-1:0] random_bit_pos();
    if ($urandom_range(99) < 8) return BIT_W'($urandom_range(BIT_MAX, STORE_BITS));
    return BIT_W'($urandom_range(STORE_BITS, 0));
  endfunction

  // Send one request; prediction happens at the accepting edge so that the
  // shadow bitmap follows the same order as the block.
  task automatic send_request(input in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_result(req));
    op_count[req.func]++;
  endtask

  function automatic in_t make_request(logic [FUNC_W-1:0] func, int widx, logic [WORD_W-1:0] wval,
                                       int first, int cnt, int last);
    in_t req;
    req.func = func;
    req.word_index = WADDR_W'(widx);
    req.word_value = wval;
    req.first_bit = BIT_W'(first);
    req.cut_count = BIT_W'(cnt);
    req.end_bit = BIT_W'(last);
    return req;
  endfunction

  // Receiver side: random back-pressure at the current stall rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result run_start=%0d run_end=%0d read_value=%h",
                 $time, out_data.run_start, out_data.run_end, out_data.read_value);
      end else begin
        exp_res = expected_results.pop_front();
        results_checked++;
        if (out_data.run_start !== exp_res.run_start) begin
          error_count++;
          $display("%0t: run_start expected %0d actual %0d",
                   $time, exp_res.run_start, out_data.run_start);
        end
        if (out_data.run_end !== exp_res.run_end) begin
          error_count++;
          $display("%0t: run_end expected %0d actual %0d",
                   $time, exp_res.run_end, out_data.run_end);
        end
        if (out_data.read_value !== exp_res.read_value) begin
          error_count++;
          $display("%0t: read_value expected %h actual %h",
                   $time, exp_res.read_value, out_data.read_value);
        end
      end
    end
  end

  // Fresh out of reset the first and last words read zero and a full-range find comes back empty.
  task automatic test_reset_state();
    send_request(make_request(FUNC_READ, 0, '0, 0, 0, 0));
    send_request(make_request(FUNC_READ, WORDS - 1, '0, 0, 0, 0));
    send_request(make_request(FUNC_FIND, 0, '0, 0, 0, STORE_BITS));
  endtask

  // Word writes at both ends of the store, extreme values, then read back.
  task automatic test_word_access();
    send_request(make_request(FUNC_WRITE, 0, '1, 0, 0, 0));
    send_request(make_request(FUNC_WRITE, WORDS - 1, 64'hA5A5_5A5A_F00F_0FF0, 0, 0, 0));
    send_request(make_request(FUNC_WRITE, 1, 64'h8000_0000_0000_0001, 0, 0, 0));
    send_request(make_request(FUNC_READ, 0, '0, 0, 0, 0));
    send_request(make_request(FUNC_READ, WORDS - 1, '0, 0, 0, 0));
    send_request(make_request(FUNC_READ, 1, '0, 0, 0, 0));
  endtask

  // Find corner cases: start at or past the end, run clipped by the end,
  // run crossing a word boundary, end beyond the store.
  task automatic test_find_cases();
    send_request(make_request(FUNC_FIND, 0, '0, 10, 0, 10));
    send_request(make_request(FUNC_FIND, 0, '0, BIT_MAX, 0, 0));
    send_request(make_request(FUNC_FIND, 0, '0, 0, 0, STORE_BITS));
    send_request(make_request(FUNC_FIND, 0, '0, 30, 0, 40));
    send_request(make_request(FUNC_FIND, 0, '0, STORE_BITS - WORD_W, 0, BIT_MAX));
    send_request(make_request(FUNC_FIND, 0, '0, STORE_BITS - 1, 0, BIT_MAX));
  endtask

  // Cut corner cases: zero count, start past end, end beyond the store,
  // count larger than the range; the store is read back afterward.
  task automatic test_cut_cases();
    send_request(make_request(FUNC_CUT, 0, '0, 0, 0, STORE_BITS));
    send_request(make_request(FUNC_CUT, 0, '0, 100, 5, 50));
    send_request(make_request(FUNC_CUT, 0, '0, 3, 70, 4000));
    send_request(make_request(FUNC_CUT, 0, '0, 4000, 10, BIT_MAX));
    send_request(make_request(FUNC_CUT, 0, '0, 0, BIT_MAX, 128));
    send_request(make_request(FUNC_READ, 0, '0, 0, 0, 0));
    send_request(make_request(FUNC_READ, 1, '0, 0, 0, 0));
    send_request(make_request(FUNC_READ, WORDS - 1, '0, 0, 0, 0));
  endtask

  // Random mix of all four operations. Writes favor solid words and runs so
  // that finds see real runs and cuts move structured data.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_reqs);
    in_t req;
    int lo;
    int hi;
    int pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_reqs) begin
      // unused fields stay random as well
      req.word_index = WADDR_W'($urandom);
      req.word_value = {$urandom, $urandom};
      req.first_bit = random_bit_pos();
      req.cut_count = BIT_W'($urandom);
      req.end_bit = random_bit_pos();
      pick = $urandom_range(99);
      if (pick < 30) begin
        req.func = FUNC_WRITE;
        case ($urandom_range(4))
          0: req.word_value = '0;
          1: req.word_value = '1;
          2: req.word_value = {$urandom, $urandom} & {$urandom, $urandom};
          3: begin
            lo = $urandom_range(WORD_W - 1);
            hi = $urandom_range(WORD_W - 1, lo);
            req.word_value = ({WORD_W{1'b1}} >> (WORD_W - 1 - (hi - lo))) << lo;
          end
          default: ;
        endcase
      end else if (pick < 50) begin
        req.func = FUNC_READ;
      end else begin
        req.func = (pick < 80) ? FUNC_FIND : FUNC_CUT;
        // mostly an end a little above the start; sometimes anywhere
        if ($urandom_range(99) < 60)
          req.end_bit = BIT_W'(((int'(req.first_bit) + $urandom_range(1024)) > BIT_MAX) ?
                               BIT_MAX : int'(req.first_bit) + $urandom_range(1024));
        if ($urandom_range(99) < 75) req.cut_count = BIT_W'($urandom_range(96));
      end
      send_request(req);
    end
  endtask

  // Sweep the whole store so any corruption left by the traffic shows up.
  task automatic test_store_sweep();
    int w;
    send_idle_pct = 0;
    for (w = 0; w < WORDS; w++)
      send_request(make_request(FUNC_READ, w, {$urandom, $urandom}, $urandom, $urandom, $urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_word_access();
    test_find_cases();
    test_cut_cases();

    // no idling, sender idle 77%, receiver stalling 77%, both at 15%
    test_random_traffic(0, 0, 390);
    test_random_traffic(77, 0, 390);
    test_random_traffic(0, 77, 390);
    test_random_traffic(15, 15, 390);
    test_store_sweep();
    in_valid <= 1'b0;

    // drain, then leave room for any stray result
    while (expected_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("Requests: %0d writes, %0d reads, %0d finds, %0d cuts; %0d results checked",
             op_count[FUNC_WRITE], op_count[FUNC_READ], op_count[FUNC_FIND],
             op_count[FUNC_CUT], results_checked);
    $display("Idle patterns: none, sender-heavy, receiver-heavy, both light; %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("tb_bitmap_run_find_and_cut_unit OK");
    end else begin
      $display("tb_bitmap_run_find_and_cut_unit NOT OK");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #50_000_000;
    $display("tb_bitmap_run_find_and_cut_unit NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/bmrfc_pkg.sv
hw/rtl/bmrfc_store.sv
hw/rtl/bitmap_run_find_and_cut_unit.sv
tb/tb_bitmap_run_find_and_cut_unit.sv
